// ----- design/sacu_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sacu_pkg
// shared types and constants of the sort-and-count-unmoved block
// ---------------------------------------------------------------------------
package sacu_pkg;

    // capacity of one batch and stored score width
    localparam int MAX_ITEMS  = 64;
    localparam int SCORE_BITS = 10;

    // fixed field widths of the item interfaces
    localparam int SCORE_W = 10;
    localparam int SAME_W  = 7;

    // derived widths
    localparam int ADDR_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_W  = $clog2(MAX_ITEMS + 1);

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic               last_item;
    } t_in_item;

    typedef struct packed {
        logic [SAME_W-1:0] same_place_count;
        logic              overflow;
    } t_out_item;

    // flags of the shared compare unit
    typedef struct packed {
        logic ge;
        logic eq;
    } t_cmp_res;

endpackage

// ----- design/sort_and_count_unmoved_unit.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sort_and_count_unmoved_unit
// batch insertion sort with a count of scores left in their arrival place
// ---------------------------------------------------------------------------
// Scores arrive one item at a time; each is written to an arrival-order ram
// and inserted into a descending-order ram by walking up from the tail, one
// shared comparator deciding shift or place. The first score of a batch is
// written straight to the head, and an item that finds the store full is
// dropped. The item flagged last_item then starts a count pass that reads
// both rams at the same address, and one result item follows: the number of
// matching positions (saturating at 127) and whether any score of the batch
// was dropped. The rams have one read port each, so every step of the
// insertion walk and of the count pass has a read state and a compare state.
// The input is not ready while a walk or a count runs; a finished result
// waits in the output register while the next batch starts, and the block
// only stalls when a second result is due before the first is taken. The
// rams need no clearing: only entries below the fill count are ever read.
// ---------------------------------------------------------------------------
module sort_and_count_unmoved_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  sacu_pkg::t_in_item   i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output sacu_pkg::t_out_item  o_out
);
    import sacu_pkg::*;

    // sequencer states
    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_INS_RD  = 3'd1;
    localparam logic [2:0] S_INS_CMP = 3'd2;
    localparam logic [2:0] S_INS_PUT = 3'd3;
    localparam logic [2:0] S_CNT_RD  = 3'd4;
    localparam logic [2:0] S_CNT_CMP = 3'd5;
    localparam logic [2:0] S_OUT     = 3'd6;

    localparam logic [SAME_W-1:0] SAME_MAX = '1;

    logic [2:0]            r_state, n_state;
    logic [SCORE_BITS-1:0] r_score, n_score;
    logic                  r_last, n_last;
    logic [CNT_W-1:0]      r_count, n_count;
    logic                  r_ovf, n_ovf;
    logic [ADDR_W-1:0]     r_k, n_k;
    logic [ADDR_W-1:0]     r_idx, n_idx;
    logic [SAME_W-1:0]     r_same, n_same;
    logic                  r_out_valid, n_out_valid;
    t_out_item             r_out, n_out;

    // ram ports
    logic                  arr_we;
    logic [ADDR_W-1:0]     arr_waddr;
    logic [SCORE_BITS-1:0] arr_wdata;
    logic [ADDR_W-1:0]     arr_raddr;
    logic [SCORE_BITS-1:0] arr_rdata;
    logic                  srt_we;
    logic [ADDR_W-1:0]     srt_waddr;
    logic [SCORE_BITS-1:0] srt_wdata;
    logic [ADDR_W-1:0]     srt_raddr;
    logic [SCORE_BITS-1:0] srt_rdata;

    // shared comparator
    logic [SCORE_BITS-1:0] cmp_b;
    t_cmp_res              cmp_res;

    logic [SCORE_BITS-1:0] in_score;
    logic                  in_fire;
    logic                  out_free;
    logic                  full;

    sacu_ram #(
        .DEPTH (MAX_ITEMS),
        .WIDTH (SCORE_BITS)
    ) u_arrival_ram (
        .i_clk   (i_clk),
        .i_we    (arr_we),
        .i_waddr (arr_waddr),
        .i_wdata (arr_wdata),
        .i_raddr (arr_raddr),
        .o_rdata (arr_rdata)
    );

    sacu_ram #(
        .DEPTH (MAX_ITEMS),
        .WIDTH (SCORE_BITS)
    ) u_sorted_ram (
        .i_clk   (i_clk),
        .i_we    (srt_we),
        .i_waddr (srt_waddr),
        .i_wdata (srt_wdata),
        .i_raddr (srt_raddr),
        .o_rdata (srt_rdata)
    );

    // sorted entry against the new score while inserting, against the
    // arrival entry while counting
    assign cmp_b = (r_state == S_CNT_CMP) ? arr_rdata : r_score;

    sacu_cmp u_cmp (
        .i_a   (srt_rdata),
        .i_b   (cmp_b),
        .o_res (cmp_res)
    );

    assign in_score    = SCORE_BITS'(i_in.score);
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign full        = (r_count == CNT_W'(MAX_ITEMS));
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        n_state     = r_state;
        n_score     = r_score;
        n_last      = r_last;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_k         = r_k;
        n_idx       = r_idx;
        n_same      = r_same;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        arr_we    = 1'b0;
        arr_waddr = r_count[ADDR_W-1:0];
        arr_wdata = in_score;
        arr_raddr = r_idx;
        srt_we    = 1'b0;
        srt_waddr = r_k;
        srt_wdata = r_score;
        srt_raddr = r_idx;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_score = in_score;
                    n_last  = i_in.last_item;
                    n_idx   = '0;
                    n_same  = '0;
                    if (full) begin
                        // store full: drop the score, still honour last_item
                        n_ovf   = 1'b1;
                        n_state = i_in.last_item ? S_CNT_RD : S_IDLE;
                    end else begin
                        arr_we = 1'b1;
                        if (r_count == '0) begin
                            // first score of a batch goes straight to the head
                            srt_we    = 1'b1;
                            srt_waddr = '0;
                            srt_wdata = in_score;
                            n_count   = r_count + CNT_W'(1);
                            n_state   = i_in.last_item ? S_CNT_RD : S_IDLE;
                        end else begin
                            n_k     = r_count[ADDR_W-1:0];
                            n_state = S_INS_RD;
                        end
                    end
                end
            end

            S_INS_RD: begin
                srt_raddr = r_k - ADDR_W'(1);
                n_state   = S_INS_CMP;
            end

            S_INS_CMP: begin
                srt_we = 1'b1;
                if (cmp_res.ge) begin
                    // stored score not smaller: new score sits just below it
                    srt_wdata = r_score;
                    n_count   = r_count + CNT_W'(1);
                    n_state   = r_last ? S_CNT_RD : S_IDLE;
                end else begin
                    // shift the smaller score one place down the list
                    srt_wdata = srt_rdata;
                    n_k       = r_k - ADDR_W'(1);
                    n_state   = (r_k == ADDR_W'(1)) ? S_INS_PUT : S_INS_RD;
                end
            end

            S_INS_PUT: begin
                srt_we    = 1'b1;
                srt_wdata = r_score;
                n_count   = r_count + CNT_W'(1);
                n_state   = r_last ? S_CNT_RD : S_IDLE;
            end

            S_CNT_RD: begin
                arr_raddr = r_idx;
                srt_raddr = r_idx;
                n_state   = (r_count == '0) ? S_OUT : S_CNT_CMP;
            end

            S_CNT_CMP: begin
                if (cmp_res.eq && (r_same != SAME_MAX)) begin
                    n_same = r_same + SAME_W'(1);
                end
                n_idx = r_idx + ADDR_W'(1);
                if ((CNT_W'(r_idx) + CNT_W'(1)) == r_count) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_CNT_RD;
                end
            end

            S_OUT: begin
                if (out_free) begin
                    n_out_valid           = 1'b1;
                    n_out.same_place_count = r_same;
                    n_out.overflow        = r_ovf;
                    // batch closed: empty the stores logically
                    n_count = '0;
                    n_ovf   = 1'b0;
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    // working and payload registers
    always_ff @(posedge i_clk) begin
        r_score <= n_score;
        r_last  <= n_last;
        r_k     <= n_k;
        r_idx   <= n_idx;
        r_same  <= n_same;
        r_out   <= n_out;
    end

    // fill count never passes capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_ITEMS))
        else $error("fill count above capacity");

    // insertion walk only runs with room left and a tail position above zero
    a_walk_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS_RD || r_state == S_INS_CMP) |->
            (r_k != '0) && !full)
        else $error("insertion walk out of range");

    // count pass stays below the fill count
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CNT_CMP) |-> (CNT_W'(r_idx) < r_count))
        else $error("count pass beyond stored scores");

    // closing a batch loads a result and leaves empty stores
    a_batch_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && out_free) |=>
            r_out_valid && (r_count == '0) && !r_ovf && (r_state == S_IDLE))
        else $error("batch not closed cleanly");

endmodule

// ----- design/sacu_ram.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sacu_ram
// simple dual-port ram, one write and one registered read per cycle
// ---------------------------------------------------------------------------
module sacu_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 10
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/sacu_cmp.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sacu_cmp
// shared score comparator: greater-or-equal and equal from one subtraction
// ---------------------------------------------------------------------------
module sacu_cmp (
    input  logic [sacu_pkg::SCORE_BITS-1:0] i_a,
    input  logic [sacu_pkg::SCORE_BITS-1:0] i_b,
    output sacu_pkg::t_cmp_res              o_res
);
    import sacu_pkg::*;

    logic [SCORE_BITS:0] diff;

    // borrow out of the top bit means a < b
    assign diff       = {1'b0, i_a} - {1'b0, i_b};
    assign o_res.ge   = ~diff[SCORE_BITS];
    assign o_res.eq   = (diff == '0);

endmodule
